### src/rau_pkg.sv
package rau_pkg;

    // operand width of the input fractions
    localparam int OPERAND_BITS = 16;
    // width of products, sums and the gcd datapath
    localparam int SUM_W = 2 * OPERAND_BITS + 1;
    localparam int PROD_W = 2 * OPERAND_BITS;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CMP = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RED = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMB,
        ST_GCD,
        ST_GCD_WAIT,
        ST_DIVN_WAIT,
        ST_DIVD_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [SUM_W-1:0] quotient;
        logic [SUM_W-1:0] remainder;
    } div_rsp_t;

endpackage

### src/rau_mul.sv
module rau_mul (
    input  logic                       clk,
    input  logic [rau_pkg::OPERAND_BITS-1:0] a,
    input  logic [rau_pkg::OPERAND_BITS-1:0] b,
    output logic [rau_pkg::PROD_W-1:0]       product
);
    import rau_pkg::*;

    logic [PROD_W-1:0] product_reg;

    // unsigned magnitude product, registered
    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign product = product_reg;

endmodule

### src/rau_div.sv
module rau_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] work_reg, work_next;
    logic [SUM_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, work_reg[SUM_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (req.start)
        begin
            rem_next  = '0;
            work_next = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = diff[SUM_W-1:0];
                work_next = {work_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[SUM_W-1:0];
                work_next = {work_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = work_reg;
    assign rsp.remainder = rem_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= CNT_W'(SUM_W - 1)))
        else $error("divider bit count out of range");
`endif

endmodule

### src/rational_arithmetic_unit_top.sv
// rational arithmetic unit: add, subtract, multiply, divide, compare or
// reduce signed fractions, results brought to lowest terms by a gcd
// input channel: in_valid/in_ready carry one request of kind and two
// fractions; in_ready is high only while the sequencer is idle
// output channel: out_valid/out_ready carry result_num/result_den (sign on
// the numerator, positive denominator, both zero on compare or error),
// compare flags and error
// steps: the multiplier states MUL0 to MUL3, a combine state, then the gcd
// loop with one division per euclid step, then two divisions of numerator
// and denominator by the gcd, all on the shared bit-serial divider; reduce
// skips the multiplier and combine states; compare ends after the combine
// state; a zero denominator, zero divisor or unused kind goes straight out
// the sequencer works on one request at a time and takes the next only
// once it is back in idle
// reset clears the sequencer and the output valid; no clearing pass
// a stalled receiver holds the result in the output register; the next
// request may be taken and worked on, and waits in the final state until
// the held result is taken
module rational_arithmetic_unit_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rau_pkg::KIND_W-1:0]        kind,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] first_num,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] first_den,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] second_num,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] second_den,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rau_pkg::NUM_W-1:0]  result_num,
    output logic [rau_pkg::DEN_W-1:0]         result_den,
    output logic                              is_less,
    output logic                              is_equal,
    output logic                              is_greater,
    output logic                              error
);
    import rau_pkg::*;

    localparam int W = OPERAND_BITS;

    state_t state_reg, state_next;

    // operands held as sign and magnitude
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              n1_neg_reg, n1_neg_next;
    logic              n2_neg_reg, n2_neg_next;
    logic [W-1:0]      n1_mag_reg, n1_mag_next;
    logic [W-1:0]      n2_mag_reg, n2_mag_next;
    logic [W-1:0]      b_mag_reg, b_mag_next;
    logic [W-1:0]      d_mag_reg, d_mag_next;

    // products, numerator magnitude, denominator and gcd pair
    logic [SUM_W-1:0]  p_reg, p_next;
    logic [SUM_W-1:0]  q_reg, q_next;
    logic [SUM_W-1:0]  den_reg, den_next;
    logic [SUM_W-1:0]  m_reg, m_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  ga_reg, ga_next;
    logic [SUM_W-1:0]  gb_reg, gb_next;
    logic              err_reg, err_next;
    logic              lt_reg, lt_next;
    logic              eq_reg, eq_next;
    logic              gt_reg, gt_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]  res_num_reg, res_num_next;
    logic [DEN_W-1:0]  res_den_reg, res_den_next;
    logic              res_lt_reg, res_lt_next;
    logic              res_eq_reg, res_eq_next;
    logic              res_gt_reg, res_gt_next;
    logic              res_err_reg, res_err_next;

    // input decode
    logic [W-1:0]      in_n1_mag, in_d1_mag, in_n2_mag, in_d2_mag;
    logic              in_n1_neg, in_d1_neg, in_n2_neg, in_d2_neg;
    logic              in_err;

    // shared units
    logic [W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // combine step
    logic              p_neg, q_neg;
    logic signed [SUM_W-1:0] ps, qs, sum;
    logic [NUM_W-1:0]  num_ext;

    rau_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    rau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // two's complement to sign and magnitude; the most negative value keeps
    // its full magnitude in W unsigned bits
    always_comb
    begin
        in_n1_neg = first_num[W-1];
        in_d1_neg = first_den[W-1];
        in_n2_neg = second_num[W-1];
        in_d2_neg = second_den[W-1];
        in_n1_mag = in_n1_neg ? W'(-first_num) : W'(first_num);
        in_d1_mag = in_d1_neg ? W'(-first_den) : W'(first_den);
        in_n2_mag = in_n2_neg ? W'(-second_num) : W'(second_num);
        in_d2_mag = in_d2_neg ? W'(-second_den) : W'(second_den);
        in_err = (kind > KIND_RED) || (in_d1_mag == '0)
               || ((kind != KIND_RED) && (in_d2_mag == '0))
               || ((kind == KIND_DIV) && (in_n2_mag == '0));
    end

    // multiplier operand select per step
    always_comb
    begin
        case (state_reg)
            ST_MUL0:
            begin
                mul_a = n1_mag_reg;
                mul_b = (kind_reg == KIND_MUL) ? n2_mag_reg : d_mag_reg;
            end
            ST_MUL1:
            begin
                mul_a = n2_mag_reg;
                mul_b = b_mag_reg;
            end
            default:
            begin
                mul_a = b_mag_reg;
                mul_b = (kind_reg == KIND_DIV) ? n2_mag_reg : d_mag_reg;
            end
        endcase
    end

    // signed values of the two cross products
    always_comb
    begin
        p_neg = n1_neg_reg ^ (((kind_reg == KIND_MUL) || (kind_reg == KIND_DIV))
                              && n2_neg_reg);
        q_neg = n2_neg_reg ^ (kind_reg == KIND_SUB);
        ps    = p_neg ? -$signed(p_reg) : $signed(p_reg);
        qs    = q_neg ? -$signed(q_reg) : $signed(q_reg);
        sum   = ps + qs;
        num_ext = NUM_W'(m_reg);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        n1_neg_next    = n1_neg_reg;
        n2_neg_next    = n2_neg_reg;
        n1_mag_next    = n1_mag_reg;
        n2_mag_next    = n2_mag_reg;
        b_mag_next     = b_mag_reg;
        d_mag_next     = d_mag_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        den_next       = den_reg;
        m_next         = m_reg;
        neg_next       = neg_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        err_next       = err_reg;
        lt_next        = lt_reg;
        eq_next        = eq_reg;
        gt_next        = gt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_lt_next    = res_lt_reg;
        res_eq_next    = res_eq_reg;
        res_gt_next    = res_gt_reg;
        res_err_next   = res_err_reg;
        div_req.start    = 1'b0;
        div_req.dividend = ga_reg;
        div_req.divisor  = gb_reg;
        in_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind;
                    // denominator signs move onto the numerators
                    n1_neg_next = (in_n1_mag != '0) && (in_n1_neg ^ in_d1_neg);
                    n2_neg_next = (in_n2_mag != '0) && (in_n2_neg ^ in_d2_neg);
                    n1_mag_next = in_n1_mag;
                    n2_mag_next = in_n2_mag;
                    b_mag_next  = in_d1_mag;
                    d_mag_next  = in_d2_mag;
                    err_next    = in_err;
                    lt_next     = 1'b0;
                    eq_next     = 1'b0;
                    gt_next     = 1'b0;
                    m_next      = '0;
                    den_next    = '0;
                    neg_next    = 1'b0;
                    if (in_err)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (kind == KIND_RED)
                    begin
                        m_next     = SUM_W'(in_n1_mag);
                        neg_next   = (in_n1_mag != '0) && (in_n1_neg ^ in_d1_neg);
                        den_next   = SUM_W'(in_d1_mag);
                        ga_next    = SUM_W'(in_n1_mag);
                        gb_next    = SUM_W'(in_d1_mag);
                        state_next = ST_GCD;
                    end
                    else
                    begin
                        state_next = ST_MUL0;
                    end
                end
            end
            ST_MUL0:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                p_next     = SUM_W'(mul_p);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                q_next     = SUM_W'(mul_p);
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                den_next   = SUM_W'(mul_p);
                state_next = ST_COMB;
            end
            ST_COMB:
            begin
                if (kind_reg == KIND_CMP)
                begin
                    lt_next    = ps < qs;
                    eq_next    = ps == qs;
                    gt_next    = ps > qs;
                    den_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    if ((kind_reg == KIND_ADD) || (kind_reg == KIND_SUB))
                    begin
                        neg_next = sum[SUM_W-1];
                        m_next   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
                        ga_next  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
                    end
                    else
                    begin
                        neg_next = p_neg && (p_reg != '0);
                        m_next   = p_reg;
                        ga_next  = p_reg;
                    end
                    gb_next    = den_reg;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (gb_reg == '0)
                begin
                    // gcd found in ga, divide the numerator by it
                    div_req.start    = 1'b1;
                    div_req.dividend = m_reg;
                    div_req.divisor  = ga_reg;
                    state_next       = ST_DIVN_WAIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = div_rsp.remainder;
                    state_next = ST_GCD;
                end
            end
            ST_DIVN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    m_next           = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = den_reg;
                    div_req.divisor  = ga_reg;
                    state_next       = ST_DIVD_WAIT;
                end
            end
            ST_DIVD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    den_next   = div_rsp.quotient;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    res_num_next   = (neg_reg && !err_reg) ? -num_ext
                                   : (err_reg ? '0 : num_ext);
                    res_den_next   = err_reg ? '0 : DEN_W'(den_reg);
                    res_lt_next    = lt_reg;
                    res_eq_next    = eq_reg;
                    res_gt_next    = gt_reg;
                    res_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        n1_neg_reg  <= n1_neg_next;
        n2_neg_reg  <= n2_neg_next;
        n1_mag_reg  <= n1_mag_next;
        n2_mag_reg  <= n2_mag_next;
        b_mag_reg   <= b_mag_next;
        d_mag_reg   <= d_mag_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        den_reg     <= den_next;
        m_reg       <= m_next;
        neg_reg     <= neg_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        err_reg     <= err_next;
        lt_reg      <= lt_next;
        eq_reg      <= eq_next;
        gt_reg      <= gt_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_lt_reg  <= res_lt_next;
        res_eq_reg  <= res_eq_next;
        res_gt_reg  <= res_gt_next;
        res_err_reg <= res_err_next;
    end

    assign out_valid  = out_valid_reg;
    assign result_num = $signed(res_num_reg);
    assign result_den = res_den_reg;
    assign is_less    = res_lt_reg;
    assign is_equal   = res_eq_reg;
    assign is_greater = res_gt_reg;
    assign error      = res_err_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_err_reg) |-> (res_num_reg == '0 && res_den_reg == '0))
        else $error("error result with non-zero fraction");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({res_lt_reg, res_eq_reg, res_gt_reg}))
        else $error("more than one compare flag");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer idle");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD_WAIT) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");
`endif

endmodule

### tb/sv/rational_result_checker.sv
module rational_result_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic [rau_pkg::KIND_W-1:0]              kind,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] first_num,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] first_den,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] second_num,
    input  logic signed [rau_pkg::OPERAND_BITS-1:0] second_den,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [rau_pkg::NUM_W-1:0]        result_num,
    input  logic [rau_pkg::DEN_W-1:0]               result_den,
    input  logic                                    is_less,
    input  logic                                    is_equal,
    input  logic                                    is_greater,
    input  logic                                    error,
    output int                                      fail_count,
    output int                                      pending,
    output int                                      results_seen
);
    import rau_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             lt;
        logic             eq;
        logic             gt;
        logic             err;
    } fraction_result_t;

    fraction_result_t expected_results[$];

    function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // signed values as longint: 16-bit operands never overflow 64 bits
    function automatic fraction_result_t lowest_terms(longint n, longint d);
        fraction_result_t r;
        longint unsigned g;
        longint unsigned m;
        r = '0;
        m = (n < 0) ? -n : n;
        g = euclid(m, d);
        if (g == 0)
            g = 1;
        m = m / g;
        r.num = (n < 0) ? -longint'(m) : longint'(m);
        r.den = d / g;
        return r;
    endfunction

    function automatic fraction_result_t predict_fraction(
        logic [KIND_W-1:0] k, longint n1, longint d1, longint n2, longint d2);
        fraction_result_t r;
        longint a;
        longint b;
        r = '0;
        if (k > KIND_RED || d1 == 0 || (k != KIND_RED && d2 == 0) ||
            (k == KIND_DIV && n2 == 0))
        begin
            r.err = 1'b1;
            return r;
        end
        if (d1 < 0)
        begin
            n1 = -n1;
            d1 = -d1;
        end
        if (d2 < 0)
        begin
            n2 = -n2;
            d2 = -d2;
        end
        case (k)
            KIND_ADD: r = lowest_terms(n1 * d2 + n2 * d1, d1 * d2);
            KIND_SUB: r = lowest_terms(n1 * d2 - n2 * d1, d1 * d2);
            KIND_MUL: r = lowest_terms(n1 * n2, d1 * d2);
            KIND_DIV: r = lowest_terms((n2 < 0) ? -(n1 * d2) : n1 * d2,
                                       d1 * ((n2 < 0) ? -n2 : n2));
            KIND_CMP:
            begin
                a = n1 * d2;
                b = n2 * d1;
                r.lt = a < b;
                r.eq = a == b;
                r.gt = a > b;
            end
            default: r = lowest_terms(n1, d1);
        endcase
        return r;
    endfunction

    fraction_result_t got;
    fraction_result_t want;

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_fraction(kind, first_num, first_den,
                                                            second_num, second_den));
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                got = '{result_num, result_den, is_less, is_equal, is_greater, error};
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        if (got.num != want.num)
                            $error("result_num expected %0d got %0d",
                                   $signed(want.num), $signed(got.num));
                        if (got.den != want.den)
                            $error("result_den expected %0d got %0d", want.den, got.den);
                        if (got.lt != want.lt)
                            $error("is_less expected %0b got %0b", want.lt, got.lt);
                        if (got.eq != want.eq)
                            $error("is_equal expected %0b got %0b", want.eq, got.eq);
                        if (got.gt != want.gt)
                            $error("is_greater expected %0b got %0b", want.gt, got.gt);
                        if (got.err != want.err)
                            $error("error expected %0b got %0b", want.err, got.err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb_rational_arithmetic_unit_top.sv
module tb_rational_arithmetic_unit_top;
    import rau_pkg::*;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [KIND_W-1:0]              kind;
    logic signed [OPERAND_BITS-1:0] first_num;
    logic signed [OPERAND_BITS-1:0] first_den;
    logic signed [OPERAND_BITS-1:0] second_num;
    logic signed [OPERAND_BITS-1:0] second_den;
    logic                           out_valid;
    logic                           out_ready;
    logic signed [NUM_W-1:0]        result_num;
    logic [DEN_W-1:0]               result_den;
    logic                           is_less;
    logic                           is_equal;
    logic                           is_greater;
    logic                           error;
    int                             fail_count;
    int                             pending;
    int                             results_seen;

    // percentage of cycles on which each side holds off
    int                             send_idle_pct;
    int                             recv_stall_pct;
    int                             requests_sent;

    rational_arithmetic_unit_top dut (.*);

    rational_result_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: room for the worst-case request time plus long stalls
    initial
    begin
        #100000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls at the current rate
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_request(logic [KIND_W-1:0] k, logic [15:0] n1, logic [15:0] d1,
                                logic [15:0] n2, logic [15:0] d2);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        first_num  <= n1;
        first_den  <= d1;
        second_num <= n2;
        second_den <= d2;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // operand biased towards small values, extremes and full range
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'(-$urandom_range(12));
            3, 4, 5: return 16'($urandom_range(24)) - 16'd12;
            6:       return 16'($urandom_range(400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        logic [KIND_W-1:0] k;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            // mostly legal kinds, the unused codes now and then
            k = ($urandom_range(19) == 0) ? KIND_W'($urandom_range(7, 6))
                                          : KIND_W'($urandom_range(5));
            send_request(k, pick_operand(), pick_operand(), pick_operand(),
                         pick_operand());
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        first_num = '0;
        first_den = '0;
        second_num = '0;
        second_den = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        requests_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every kind, extremes, zero denominators, zero divisor
        send_request(KIND_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_request(KIND_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_request(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'd1);
        send_request(KIND_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_request(KIND_CMP, 16'd1, -16'd2, -16'd1, 16'd2);
        send_request(KIND_CMP, 16'h7fff, 16'd1, 16'h8000, 16'd1);
        send_request(KIND_CMP, -16'd1, 16'd3, 16'd1, 16'd3);
        send_request(KIND_RED, -16'd6, -16'd4, 16'd0, 16'd0);
        send_request(KIND_RED, 16'd0, -16'd7, 16'd5, 16'd5);
        // negative signs on both fractions, all four parts negative in the add
        send_request(KIND_ADD, -16'd3, -16'd4, -16'd5, -16'd6);
        send_request(KIND_MUL, -16'd4, -16'd6, 16'd3, -16'd2);
        send_request(KIND_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
        send_request(KIND_SUB, 16'd1, 16'd1, 16'd1, 16'd0);
        send_request(KIND_DIV, 16'd1, 16'd1, 16'd0, 16'd5);
        send_request(KIND_RED, 16'd9, 16'd0, 16'd1, 16'd1);
        send_request(3'd6, 16'd1, 16'd1, 16'd1, 16'd1);
        send_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_request(KIND_ADD, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        send_request(KIND_DIV, 16'h8000, 16'd1, 16'h7fff, 16'h8000);

        random_phase(350, 0, 0);
        // hold off until the unit has emptied
        drain();
        random_phase(320, 74, 0);
        random_phase(320, 0, 74);
        random_phase(320, 32, 32);

        drain();
        repeat (400) @(posedge clk);
        $display("covered %0d requests over all six kinds plus unused codes, %0d results",
                 requests_sent, results_seen);
        $display("idling phases: none, sender idle, receiver stalled, both");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
